/* rtl/tournament_branch_predictor_assert.svh */
// Assertion macros shared by the tournament branch predictor RTL.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBP_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
    else $error("tournament branch predictor: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TBP_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
    else $error("tournament branch predictor: next-cycle check failed");

`endif

/* rtl/tbp_pkg.sv */
// Package with the defaults, field positions and constants of the branch predictor.
`default_nettype none
package tbp_pkg;

  localparam int unsigned TBP_LOCAL_INDEX_BITS    = 10;
  localparam int unsigned TBP_HISTORY_BITS        = 12;
  localparam int unsigned TBP_LOCAL_COUNTER_BITS  = 2;
  localparam int unsigned TBP_GLOBAL_COUNTER_BITS = 2;
  localparam int unsigned TBP_CHOICE_COUNTER_BITS = 2;

  localparam logic [15:0] TBP_HIST_RESET = 16'h0aaa;

  localparam int unsigned TBP_PC_W        = 32;
  localparam int unsigned TBP_S_TDATA_W   = 40;
  localparam int unsigned TBP_M_TDATA_W   = 8;
  localparam int unsigned TBP_COND_BIT    = 32;
  localparam int unsigned TBP_INDIR_BIT   = 33;
  localparam int unsigned TBP_OUTCOME_BIT = 34;

  typedef enum logic {
    TBP_ACT_PREDICT = 1'b0,
    TBP_ACT_UPDATE  = 1'b1
  } tbp_action_e;

endpackage
`default_nettype wire

/* rtl/tournament_branch_predictor.sv */
// Top level of the tournament branch predictor with its counter tables and history.
`default_nettype none
`include "tournament_branch_predictor_assert.svh"

// The predictor takes one predict or update transfer per clock cycle while s_axis_tready is
// high; a pending prediction whose result register is held by m_axis_tready stalls intake. A
// request is captured in the table read register and its prediction then in the result
// register; updates produce no output transfer. The local, global and choice tables are single
// memories written by the preceding request while the next one reads them, with a one-entry
// bypass covering that overlap. After reset a clearing pass loads the reset counter values
// into every table entry, during which s_axis_tready stays low.
module tournament_branch_predictor
  import tbp_pkg::*;
#(
  parameter int unsigned LOCAL_INDEX_BITS    = TBP_LOCAL_INDEX_BITS,
  parameter int unsigned HISTORY_BITS        = TBP_HISTORY_BITS,
  parameter int unsigned LOCAL_COUNTER_BITS  = TBP_LOCAL_COUNTER_BITS,
  parameter int unsigned GLOBAL_COUNTER_BITS = TBP_GLOBAL_COUNTER_BITS,
  parameter int unsigned CHOICE_COUNTER_BITS = TBP_CHOICE_COUNTER_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: pc[31:0], conditional flag, indirect flag, outcome, zero fill.
  input  wire logic [TBP_S_TDATA_W-1:0] s_axis_tdata,
  // Fields from bit 0: action.
  input  wire logic                     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // Fields from bit 0: predict_taken, zero fill.
  output logic [TBP_M_TDATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned LocalDepth = 2 ** LOCAL_INDEX_BITS;
  localparam int unsigned HistDepth  = 2 ** HISTORY_BITS;
  localparam int unsigned ClrBits    = (LOCAL_INDEX_BITS > HISTORY_BITS) ?
                                       LOCAL_INDEX_BITS : HISTORY_BITS;
  localparam logic [HISTORY_BITS-1:0] HistInit = TBP_HIST_RESET[HISTORY_BITS-1:0];
  localparam logic [CHOICE_COUNTER_BITS-1:0] ChoiceInit =
    CHOICE_COUNTER_BITS'((1 << (CHOICE_COUNTER_BITS - 1)) - 1);

  typedef logic [LOCAL_INDEX_BITS-1:0]    lidx_t;
  typedef logic [HISTORY_BITS-1:0]        hidx_t;
  typedef logic [LOCAL_COUNTER_BITS-1:0]  lctr_t;
  typedef logic [GLOBAL_COUNTER_BITS-1:0] gctr_t;
  typedef logic [CHOICE_COUNTER_BITS-1:0] cctr_t;

  lctr_t local_mem  [LocalDepth];
  gctr_t global_mem [HistDepth];
  cctr_t choice_mem [HistDepth];

  logic               clr_busy_q;
  logic [ClrBits-1:0] clr_cnt_q;
  hidx_t              hist_q;

  logic               s1_valid_q;
  logic               s1_action_q;
  logic               s1_cond_q;
  logic               s1_indir_q;
  logic               s1_outcome_q;
  lidx_t              s1_li_q;
  hidx_t              s1_hi_q;

  lctr_t              rd_local_q;
  gctr_t              rd_global_q;
  cctr_t              rd_choice_q;
  logic               fwd_local_q;
  logic               fwd_global_q;
  logic               fwd_choice_q;
  lctr_t              fwd_local_data_q;
  gctr_t              fwd_global_data_q;
  cctr_t              fwd_choice_data_q;

  logic               out_valid_q;
  logic               out_taken_q;

  logic               s_accept;
  logic               s1_adv;
  logic               out_load;
  logic               upd_we;
  lidx_t              in_li;
  logic               in_update;
  lctr_t              lc, lc_new;
  gctr_t              gc, gc_new;
  cctr_t              cc, cc_new;
  logic               lp, gp, cp;
  logic               pred;

  assign in_li     = s_axis_tdata[LOCAL_INDEX_BITS-1:0];
  assign in_update = (s_axis_tuser == TBP_ACT_UPDATE) &&
                     (s_axis_tdata[TBP_COND_BIT] || s_axis_tdata[TBP_INDIR_BIT]);

  assign s1_adv        = !(s1_action_q == TBP_ACT_PREDICT) || !out_valid_q || m_axis_tready;
  assign s_axis_tready = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign lc = fwd_local_q  ? fwd_local_data_q  : rd_local_q;
  assign gc = fwd_global_q ? fwd_global_data_q : rd_global_q;
  assign cc = fwd_choice_q ? fwd_choice_data_q : rd_choice_q;
  assign lp = lc[LOCAL_COUNTER_BITS-1];
  assign gp = gc[GLOBAL_COUNTER_BITS-1];
  assign cp = cc[CHOICE_COUNTER_BITS-1];

  always_comb begin
    pred = 1'b1;
    if (s1_cond_q) begin
      pred = cp ? gp : lp;
    end
    if (s1_outcome_q) begin
      lc_new = (lc == '1) ? lc : lc + 1'b1;
      gc_new = (gc == '1) ? gc : gc + 1'b1;
    end else begin
      lc_new = (lc == '0) ? lc : lc - 1'b1;
      gc_new = (gc == '0) ? gc : gc - 1'b1;
    end
    cc_new = cc;
    if (lp != gp) begin
      if (gp == s1_outcome_q) begin
        cc_new = (cc == '1) ? cc : cc + 1'b1;
      end else begin
        cc_new = (cc == '0) ? cc : cc - 1'b1;
      end
    end
  end

  assign upd_we   = s1_valid_q && (s1_action_q == TBP_ACT_UPDATE) && (s1_cond_q || s1_indir_q);
  assign out_load = s1_valid_q && (s1_action_q == TBP_ACT_PREDICT) && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      hist_q      <= HistInit;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        if (clr_cnt_q == '1) begin
          clr_busy_q <= 1'b0;
        end
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (s_accept && in_update) begin
        hist_q <= {hist_q[HISTORY_BITS-2:0], s_axis_tdata[TBP_OUTCOME_BIT]};
      end
      if (s_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_action_q  <= s_axis_tuser;
      s1_cond_q    <= s_axis_tdata[TBP_COND_BIT];
      s1_indir_q   <= s_axis_tdata[TBP_INDIR_BIT];
      s1_outcome_q <= s_axis_tdata[TBP_OUTCOME_BIT];
      s1_li_q      <= in_li;
      s1_hi_q      <= hist_q;
      rd_local_q   <= local_mem[in_li];
      rd_global_q  <= global_mem[hist_q];
      rd_choice_q  <= choice_mem[hist_q];
      fwd_local_q  <= upd_we && (s1_li_q == in_li);
      fwd_global_q <= upd_we && (s1_hi_q == hist_q);
      fwd_choice_q <= upd_we && (s1_hi_q == hist_q);
      fwd_local_data_q  <= lc_new;
      fwd_global_data_q <= gc_new;
      fwd_choice_data_q <= cc_new;
    end
    if (out_load) begin
      out_taken_q <= pred;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      local_mem[clr_cnt_q[LOCAL_INDEX_BITS-1:0]] <= '0;
      global_mem[clr_cnt_q[HISTORY_BITS-1:0]]    <= '0;
      choice_mem[clr_cnt_q[HISTORY_BITS-1:0]]    <= ChoiceInit;
    end else if (upd_we) begin
      local_mem[s1_li_q]  <= lc_new;
      global_mem[s1_hi_q] <= gc_new;
      choice_mem[s1_hi_q] <= cc_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TBP_M_TDATA_W-1){1'b0}}, out_taken_q};

  `TBP_ASSERT_IMPLY(a_no_accept_in_clear, clk_i, rst_ni, clr_busy_q, !s_axis_tready)
  `TBP_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, s1_valid_q && !s1_adv, $stable({rd_local_q, s1_hi_q}))
  `TBP_ASSERT_NEXT(a_hist_only_on_update, clk_i, rst_ni, !(s_accept && in_update), $stable(hist_q))
  `TBP_ASSERT_IMPLY(a_update_never_stalls, clk_i, rst_ni, upd_we, s1_adv && !out_load)

endmodule
`default_nettype wire
